/* design/subpicture_rle_decoder_defines.svh */
// ----------------------------------------------------------------------------
// Subpicture RLE decoder assertion macros
// Shared property forms for the port checker. The user supplies clk and
// arst_n in the scope where a macro is used.
// ----------------------------------------------------------------------------
`ifndef SUBPICTURE_RLE_DECODER_DEFINES_SVH
`define SUBPICTURE_RLE_DECODER_DEFINES_SVH

// same-cycle implication
`define SPRLE_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sprle: same-cycle check failed");

// next-cycle implication
`define SPRLE_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sprle: next-cycle check failed");

`endif

/* design/sprle_pkg.sv */
// ----------------------------------------------------------------------------
// Subpicture RLE decoder package
// Types, constants and register indexes shared by the decoder modules.
// ----------------------------------------------------------------------------
package sprle_pkg;

	localparam int DEF_QUEUE_DEPTH = 2;

	localparam logic [9:0] WIDTH_RESET  = 10'd720;
	localparam logic [9:0] HEIGHT_RESET = 10'd480;
	localparam logic [9:0] MIN_WIDTH    = 10'd64;

	// configuration register indexes
	localparam logic REG_IMAGE_WIDTH  = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	// code completion thresholds
	localparam logic [15:0] CODE1_MIN = 16'h0004;
	localparam logic [15:0] CODE2_MIN = 16'h0010;
	localparam logic [15:0] CODE3_MIN = 16'h0040;
	localparam logic [15:0] FILL_MAX  = 16'h0003;

	typedef enum logic [1:0] {
		PH_TOP,
		PH_SKIP,
		PH_BOTTOM,
		PH_DONE
	} phase_t;

	typedef enum logic [1:0] {
		ST_NIBBLE,
		ST_RUN,
		ST_FLUSH
	} back_state_t;

	typedef struct packed {
		logic [3:0] hi_nib;
		logic [3:0] lo_nib;
		logic       bottom_start;
		logic       last_byte;
	} item_t;

	typedef struct packed {
		logic [9:0] row;
		logic [9:0] column;
		logic [9:0] run_length;
		logic [1:0] colour;
	} seg_t;

	typedef struct packed {
		logic push;   // new segment into the pending slot
		logic close;  // byte finished: send pending segment marked last
	} emit_ctl_t;

endpackage

/* design/sprle_front.sv */
// ----------------------------------------------------------------------------
// Subpicture RLE front end
// Accepts coded bytes, splits them into nibbles with their marks and holds
// them in a short queue for the decoder.
// ----------------------------------------------------------------------------
module sprle_front #(
	parameter int DEPTH = sprle_pkg::DEF_QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          rle_byte,
	input  logic                bottom_start,
	input  logic                last_byte,
	output logic                head_valid,
	output sprle_pkg::item_t    head,
	input  logic                pop
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	sprle_pkg::item_t   mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               push;
	sprle_pkg::item_t   item_in;

	assign in_stall   = (count_q == CNT_W'(DEPTH));
	assign push       = in_valid && !in_stall;
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_comb begin
		item_in.hi_nib       = rle_byte[7:4];
		item_in.lo_nib       = rle_byte[3:0];
		item_in.bottom_start = bottom_start;
		item_in.last_byte    = last_byte;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* design/sprle_back.sv */
// ----------------------------------------------------------------------------
// Subpicture RLE decode sequencer
// Builds variable-length codes one nibble a cycle, splits runs into line
// segments one a cycle, tracks row, column and field; waits on a full slot.
// ----------------------------------------------------------------------------
module sprle_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [9:0]              image_width,
	input  logic [9:0]              image_height,
	input  logic                    head_valid,
	input  sprle_pkg::item_t        head,
	output logic                    pop,
	output sprle_pkg::emit_ctl_t    ctl,
	output sprle_pkg::seg_t         seg,
	input  logic                    emit_ready
);

	sprle_pkg::back_state_t state_q, state_d;
	sprle_pkg::phase_t      phase_q, ph_d, ph_b;
	logic [11:0]            accum_q, acc_d, acc_b;
	logic [1:0]             nheld_q, nh_d, nh_b;
	logic [9:0]             col_q, col_d, col_b;
	logic [10:0]            row_q, row_d, row_b;
	logic                   sel_q, sel_d;
	logic                   drop_q, drop_d;
	logic [13:0]            run_q, run_d;
	logic [1:0]             colour_q, colour_d;

	logic                   bs_apply;
	logic [9:0]             w;
	logic [3:0]             nib;
	logic [15:0]            code;
	logic                   code_done;
	logic                   is_fill;
	logic                   dec_b;
	logic [10:0]            row_next;
	logic [9:0]             room;
	logic [9:0]             seg_len;
	logic [10:0]            col_sum;
	logic                   le;
	logic                   adv;
	logic                   push;
	logic                   finish;
	logic                   commit;

	assign w    = (image_width < sprle_pkg::MIN_WIDTH) ? sprle_pkg::MIN_WIDTH : image_width;
	assign nib  = sel_q ? head.lo_nib : head.hi_nib;

	// a bottom-field mark while skipping restarts decoding at row 1
	assign bs_apply = (state_q == sprle_pkg::ST_NIBBLE) && head_valid && !sel_q
		&& head.bottom_start && (phase_q == sprle_pkg::PH_SKIP);

	always_comb begin
		if (bs_apply) begin
			ph_b  = sprle_pkg::PH_BOTTOM;
			acc_b = '0;
			nh_b  = '0;
			col_b = '0;
			row_b = 11'd1;
		end else begin
			ph_b  = phase_q;
			acc_b = accum_q;
			nh_b  = nheld_q;
			col_b = col_q;
			row_b = row_q;
		end
	end

	assign dec_b    = (ph_b == sprle_pkg::PH_TOP) || (ph_b == sprle_pkg::PH_BOTTOM);
	assign code     = {acc_b, nib};
	assign is_fill  = (nh_b == 2'd3) && (code <= sprle_pkg::FILL_MAX);
	assign row_next = row_b + 11'd2;
	assign room     = w - col_q;
	assign seg_len  = (run_q < {4'b0, room}) ? run_q[9:0] : room;
	assign col_sum  = {1'b0, col_q} + {1'b0, seg_len};

	always_comb begin
		case (nh_b)
			2'd0:    code_done = (code >= sprle_pkg::CODE1_MIN);
			2'd1:    code_done = (code >= sprle_pkg::CODE2_MIN);
			2'd2:    code_done = (code >= sprle_pkg::CODE3_MIN);
			default: code_done = 1'b1;
		endcase
	end

	always_comb begin
		state_d  = state_q;
		ph_d     = ph_b;
		acc_d    = acc_b;
		nh_d     = nh_b;
		col_d    = col_b;
		row_d    = row_b;
		sel_d    = sel_q;
		drop_d   = drop_q;
		run_d    = run_q;
		colour_d = colour_q;
		le       = 1'b0;
		adv      = 1'b0;
		push     = 1'b0;
		finish   = 1'b0;
		seg.row        = row_b[9:0];
		seg.column     = col_b;
		seg.run_length = seg_len;
		seg.colour     = colour_q;

		case (state_q)
			sprle_pkg::ST_NIBBLE: begin
				if (head_valid) begin
					if (!dec_b) begin
						adv = 1'b1;
					end else if (row_b >= {1'b0, image_height}) begin
						ph_d = (ph_b == sprle_pkg::PH_TOP) ? sprle_pkg::PH_SKIP
							: sprle_pkg::PH_DONE;
						adv  = 1'b1;
					end else if (!code_done) begin
						acc_d = code[11:0];
						nh_d  = nh_b + 2'd1;
						adv   = 1'b1;
					end else begin
						acc_d = '0;
						nh_d  = '0;
						if (is_fill) begin
							// fill to the end of the line
							if (col_b < w) begin
								push           = 1'b1;
								seg.run_length = w - col_b;
								seg.colour     = code[1:0];
							end
							le  = 1'b1;
							adv = 1'b1;
						end else begin
							run_d    = code[15:2];
							colour_d = code[1:0];
							state_d  = sprle_pkg::ST_RUN;
						end
					end
				end
			end
			sprle_pkg::ST_RUN: begin
				if ((run_q == '0) || !dec_b) begin
					adv = 1'b1;
				end else if (col_q >= w) begin
					le = 1'b1;
				end else begin
					push  = 1'b1;
					col_d = col_sum[9:0];
					run_d = run_q - {4'b0, seg_len};
					if (col_sum >= {1'b0, w}) begin
						le = 1'b1;
					end
				end
			end
			sprle_pkg::ST_FLUSH: begin
				finish = emit_ready;
			end
			default: begin
				state_d = sprle_pkg::ST_NIBBLE;
			end
		endcase

		// line end: wrap to the next row of this field, drop the rest of the byte
		if (le) begin
			drop_d = 1'b1;
			col_d  = '0;
			acc_d  = '0;
			nh_d   = '0;
			row_d  = row_next;
			if (row_next >= {1'b0, image_height}) begin
				ph_d = (ph_b == sprle_pkg::PH_TOP) ? sprle_pkg::PH_SKIP : sprle_pkg::PH_DONE;
			end
		end

		if (adv) begin
			if (!sel_q && !drop_d) begin
				sel_d   = 1'b1;
				state_d = sprle_pkg::ST_NIBBLE;
			end else if (!push && emit_ready) begin
				finish = 1'b1;
			end else begin
				state_d = sprle_pkg::ST_FLUSH;
			end
		end

		if (finish) begin
			sel_d   = 1'b0;
			drop_d  = 1'b0;
			state_d = sprle_pkg::ST_NIBBLE;
			if (head.last_byte) begin
				ph_d  = sprle_pkg::PH_TOP;
				acc_d = '0;
				nh_d  = '0;
				col_d = '0;
				row_d = '0;
			end
		end
	end

	// hold the whole step while the segment slot is full
	assign commit    = !(push && !emit_ready);
	assign ctl.push  = push && emit_ready;
	assign ctl.close = finish;
	assign pop       = finish;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sprle_pkg::ST_NIBBLE;
			phase_q <= sprle_pkg::PH_TOP;
			accum_q <= '0;
			nheld_q <= '0;
			col_q   <= '0;
			row_q   <= '0;
			sel_q   <= 1'b0;
			drop_q  <= 1'b0;
		end else if (commit) begin
			state_q <= state_d;
			phase_q <= ph_d;
			accum_q <= acc_d;
			nheld_q <= nh_d;
			col_q   <= col_d;
			row_q   <= row_d;
			sel_q   <= sel_d;
			drop_q  <= drop_d;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			run_q    <= run_d;
			colour_q <= colour_d;
		end
	end

endmodule

/* design/sprle_emit.sv */
// ----------------------------------------------------------------------------
// Subpicture RLE segment output stage
// Holds one segment back until the next one or the end of its byte is known,
// so the last segment of a byte can be marked, then drives the output register.
// ----------------------------------------------------------------------------
module sprle_emit (
	input  logic                    clk,
	input  logic                    arst_n,
	input  sprle_pkg::emit_ctl_t    ctl,
	input  sprle_pkg::seg_t         seg,
	output logic                    ready,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [9:0]              row,
	output logic [9:0]              column,
	output logic [9:0]              run_length,
	output logic [1:0]              colour,
	output logic                    last_of_run
);

	logic               pend_v_q;
	sprle_pkg::seg_t    pend_q;
	logic               out_v_q;
	sprle_pkg::seg_t    out_q;
	logic               out_last_q;
	logic               out_free;
	logic               move;

	assign out_free = !out_v_q || !out_stall;
	assign ready    = !pend_v_q || out_free;
	assign move     = pend_v_q && (ctl.push || ctl.close);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (move) begin
				out_v_q <= 1'b1;
			end else if (!out_stall) begin
				out_v_q <= 1'b0;
			end
			if (ctl.push) begin
				pend_v_q <= 1'b1;
			end else if (ctl.close) begin
				pend_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			out_q      <= pend_q;
			out_last_q <= ctl.close;
		end
		if (ctl.push) begin
			pend_q <= seg;
		end
	end

	assign out_valid   = out_v_q;
	assign row         = out_q.row;
	assign column      = out_q.column;
	assign run_length  = out_q.run_length;
	assign colour      = out_q.colour;
	assign last_of_run = out_last_q;

endmodule

/* design/subpicture_rle_decoder.sv */
// ----------------------------------------------------------------------------
// Subpicture RLE decoder
// Decodes interlaced 2-bit run-length coded subpicture bytes into run
// segments (row, column, length, colour).
//
//   channel   direction  handshake              payload
//   input     in         in_valid / in_stall    rle_byte, bottom_start, last_byte
//   output    out        out_valid / out_stall  row, column, run_length, colour,
//                                               last_of_run
//   config    in         wr_en                  wr_index, wr_data
//
// The sequencer takes a byte one nibble at a time; a fill code completed by
// the low nibble may add a flush step. Each run takes a step per line segment
// and a closing step, and one more for a line end taken before it.
// Segments leave through a pending slot and the output register, so a byte
// whose last segment is still held waits on a stalled output. The two-entry
// byte queue accepts while the sequencer is held and stalls the input when full.
// Reset clears the queue, the decode state and the output; it sets the
// image size registers to 720 by 480.
// ----------------------------------------------------------------------------
module subpicture_rle_decoder #(
	parameter int QUEUE_DEPTH = sprle_pkg::DEF_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rle_byte,
	input  logic        bottom_start,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [9:0]  row,
	output logic [9:0]  column,
	output logic [9:0]  run_length,
	output logic [1:0]  colour,
	output logic        last_of_run,
	input  logic        wr_en,
	input  logic        wr_index,
	input  logic [9:0]  wr_data
);

	logic [9:0]             width_q;
	logic [9:0]             height_q;
	logic                   head_valid;
	sprle_pkg::item_t       head;
	logic                   pop;
	sprle_pkg::emit_ctl_t   ctl;
	sprle_pkg::seg_t        seg;
	logic                   emit_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= sprle_pkg::WIDTH_RESET;
			height_q <= sprle_pkg::HEIGHT_RESET;
		end else if (wr_en) begin
			case (wr_index)
				sprle_pkg::REG_IMAGE_WIDTH:  width_q  <= wr_data;
				sprle_pkg::REG_IMAGE_HEIGHT: height_q <= wr_data;
				default: ;
			endcase
		end
	end

	sprle_front #(
		.DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rle_byte     (rle_byte),
		.bottom_start (bottom_start),
		.last_byte    (last_byte),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop)
	);

	sprle_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.image_width  (width_q),
		.image_height (height_q),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.ctl          (ctl),
		.seg          (seg),
		.emit_ready   (emit_ready)
	);

	sprle_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.seg         (seg),
		.ready       (emit_ready),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.row         (row),
		.column      (column),
		.run_length  (run_length),
		.colour      (colour),
		.last_of_run (last_of_run)
	);

endmodule

/* design/sprle_checker.sv */
// ----------------------------------------------------------------------------
// Subpicture RLE decoder port checker
// Watches the output port for segment sanity and a held stalled transfer.
// ----------------------------------------------------------------------------
`include "subpicture_rle_decoder_defines.svh"

module sprle_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [9:0]  row,
	input  logic [9:0]  column,
	input  logic [9:0]  run_length,
	input  logic [1:0]  colour,
	input  logic        last_of_run
);

	// every segment covers at least one pixel
	`SPRLE_ASSERT_IMP(a_len_nonzero, out_valid, run_length != 10'd0)

	// a segment never runs past the widest possible line
	`SPRLE_ASSERT_IMP(a_seg_in_line, out_valid, (11'(column) + 11'(run_length)) <= 11'd1023)

	// a stalled transfer holds its segment
	`SPRLE_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(row) && $stable(column) && $stable(run_length) && $stable(colour) && $stable(last_of_run))

endmodule

bind subpicture_rle_decoder sprle_checker u_sprle_checker (.*);
